>>> rtl/core/aqfp_pkg.sv
package aqfp_pkg;

   localparam int FRAME_MAX  = 19;
   localparam int IDX_W      = 5;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [7:0] PRE_LEGACY    = 8'h3C;
   localparam logic [7:0] PRE_NEW       = 8'h01;
   localparam logic [7:0] LEGACY_SECOND = 8'h02;

   localparam logic [IDX_W-1:0] LAST_IDX_LEGACY = 5'd16;
   localparam logic [IDX_W-1:0] LAST_IDX_NEW    = 5'd18;
   localparam logic [IDX_W-1:0] FIRST_DATA_IDX  = 5'd1;

   localparam logic [11:0] TEMP_OFFSET = 12'd1280;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_PM_LIMIT = 2'd0;
   localparam logic [1:0] REG_TEMP_MIN = 2'd1;
   localparam logic [1:0] REG_TEMP_MAX = 2'd2;
   localparam logic [1:0] REG_HUM_MAX  = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CHECKSUM = 2'd1,
      STATUS_HEADER   = 2'd2,
      STATUS_IMPLAUS  = 2'd3
   } status_type;

   typedef struct packed {
      logic        [15:0] pm_limit;
      logic signed [11:0] temp_min;
      logic signed [11:0] temp_max;
      logic        [11:0] hum_max;
   } cfg_type;

   typedef logic [FRAME_MAX-1:0][7:0] frame_store_type;

   typedef struct packed {
      logic       at_last;   // next accepted byte closes the frame
      logic       done;      // closing byte accepted this cycle
      logic       is_new;
      logic [7:0] last_byte;
      logic [7:0] sum;
   } frame_view_type;

endpackage

>>> rtl/core/aqfp_req_if.sv
interface aqfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/aqfp_rsp_if.sv
interface aqfp_rsp_if;
   logic               valid;
   logic               ready;
   logic               frame_kind;
   logic        [1:0]  status;
   logic        [7:0]  device_address;
   logic        [15:0] function_code;
   logic        [15:0] co2_ppm;
   logic        [15:0] formaldehyde;
   logic        [15:0] tvoc;
   logic        [15:0] pm25;
   logic        [15:0] pm10;
   logic signed [11:0] temperature_tenths;
   logic        [11:0] humidity_tenths;

   modport source (output valid, output frame_kind, output status, output device_address,
                   output function_code, output co2_ppm, output formaldehyde, output tvoc,
                   output pm25, output pm10, output temperature_tenths,
                   output humidity_tenths, input ready);
   modport sink   (input valid, input frame_kind, input status, input device_address,
                   input function_code, input co2_ppm, input formaldehyde, input tvoc,
                   input pm25, input pm10, input temperature_tenths,
                   input humidity_tenths, output ready);
endinterface

>>> rtl/core/aqfp_csr.sv
module aqfp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [aqfp_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [aqfp_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [aqfp_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output aqfp_pkg::cfg_type                   cfg
);
   import aqfp_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PM_LIMIT: cfg_in.pm_limit = pwdata[15:0];
            REG_TEMP_MIN: cfg_in.temp_min = $signed(pwdata[11:0]);
            REG_TEMP_MAX: cfg_in.temp_max = $signed(pwdata[11:0]);
            REG_HUM_MAX:  cfg_in.hum_max  = pwdata[11:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pm_limit <= 16'd1000;
         cfg_ff.temp_min <= -12'sd400;
         cfg_ff.temp_max <= 12'sd800;
         cfg_ff.hum_max  <= 12'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PM_LIMIT: prdata = {16'd0, cfg_ff.pm_limit};
         REG_TEMP_MIN: prdata = {{20{cfg_ff.temp_min[11]}}, cfg_ff.temp_min};
         REG_TEMP_MAX: prdata = {{20{cfg_ff.temp_max[11]}}, cfg_ff.temp_max};
         REG_HUM_MAX:  prdata = {20'd0, cfg_ff.hum_max};
         default:      prdata = '0;
      endcase
   end

endmodule

>>> rtl/core/aqfp_framer.sv
module aqfp_framer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    rx_byte,
   output aqfp_pkg::frame_view_type      view,
   output aqfp_pkg::frame_store_type     store
);
   import aqfp_pkg::*;

   logic             in_frame_ff, in_frame_in;
   logic             is_new_ff, is_new_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       sum_ff, sum_in;
   frame_store_type  bytes_ff;
   logic             at_last;
   logic             preamble;

   assign preamble = (rx_byte == PRE_LEGACY) || (rx_byte == PRE_NEW);
   assign at_last  = in_frame_ff && (idx_ff == (is_new_ff ? LAST_IDX_NEW : LAST_IDX_LEGACY));

   always_comb begin
      in_frame_in = in_frame_ff;
      is_new_in   = is_new_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      if (accept) begin
         if (!in_frame_ff) begin
            if (preamble) begin
               in_frame_in = 1'b1;
               is_new_in   = (rx_byte == PRE_NEW);
               idx_in      = FIRST_DATA_IDX;
               sum_in      = rx_byte;
            end
         end else if (at_last) begin
            in_frame_in = 1'b0;
            idx_in      = '0;
            sum_in      = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
            sum_in = sum_ff + rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         is_new_ff   <= 1'b0;
         idx_ff      <= '0;
         sum_ff      <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         is_new_ff   <= is_new_in;
         idx_ff      <= idx_in;
         sum_ff      <= sum_in;
      end
   end

   // byte store, preamble and payload
   always_ff @(posedge clock) begin
      if (accept) begin
         if (!in_frame_ff) begin
            if (preamble) begin
               bytes_ff[0] <= rx_byte;
            end
         end else begin
            bytes_ff[idx_ff] <= rx_byte;
         end
      end
   end

   assign store          = bytes_ff;
   assign view.at_last   = at_last;
   assign view.done      = accept && at_last;
   assign view.is_new    = is_new_ff;
   assign view.last_byte = rx_byte;
   assign view.sum       = sum_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_IDX_NEW)
      else $error("byte index ran past the longest frame");

   a_hunt_clean: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (idx_ff == '0) && (sum_ff == '0))
      else $error("hunting with stale index or sum");

   a_done_hunts: assert property (@(posedge clock) disable iff (reset)
      (accept && at_last) |=> !in_frame_ff)
      else $error("frame did not close after its last byte");

endmodule

>>> rtl/core/aqfp_decode.sv
module aqfp_decode (
   input  logic                       clock,
   input  logic                       reset,
   input  aqfp_pkg::frame_view_type   view,
   input  aqfp_pkg::frame_store_type  store,
   input  aqfp_pkg::cfg_type          cfg,
   output logic                       busy,
   aqfp_rsp_if.source                 rsp
);
   import aqfp_pkg::*;

   typedef struct packed {
      logic               frame_kind;
      status_type         status;
      logic        [7:0]  device_address;
      logic        [15:0] function_code;
      logic        [15:0] co2_ppm;
      logic        [15:0] formaldehyde;
      logic        [15:0] tvoc;
      logic        [15:0] pm25;
      logic        [15:0] pm10;
      logic signed [11:0] temperature_tenths;
      logic        [11:0] humidity_tenths;
   } result_type;

   result_type  res_ff, res_in;
   logic        valid_ff, valid_in;
   logic [7:0]  t_int, t_frac, h_int, h_frac;
   logic [11:0] t_raw, h_raw;
   logic signed [11:0] temp;
   logic        implausible;

   // new frames sit one byte later than legacy ones
   function automatic logic [15:0] word_at(input frame_store_type s,
                                           input logic [IDX_W-1:0] i);
      return {s[i], s[i + 1'b1]};
   endfunction

   always_comb begin
      t_int  = view.is_new ? store[13] : store[12];
      t_frac = view.is_new ? store[14] : store[13];
      h_int  = view.is_new ? store[15] : store[14];
      h_frac = view.is_new ? store[16] : store[15];
      t_raw  = {1'b0, t_int, 3'b000} + {3'b000, t_int, 1'b0} + {4'b0000, t_frac};
      h_raw  = {1'b0, h_int, 3'b000} + {3'b000, h_int, 1'b0} + {4'b0000, h_frac};
      temp   = (t_raw > TEMP_OFFSET) ? $signed(TEMP_OFFSET - t_raw) : $signed(t_raw);

      res_in.frame_kind     = view.is_new;
      res_in.device_address = view.is_new ? store[0] : 8'd0;
      res_in.function_code  = view.is_new ? word_at(store, 5'd1) : 16'd0;
      res_in.co2_ppm        = view.is_new ? word_at(store, 5'd3)  : word_at(store, 5'd2);
      res_in.formaldehyde   = view.is_new ? word_at(store, 5'd5)  : word_at(store, 5'd4);
      res_in.tvoc           = view.is_new ? word_at(store, 5'd7)  : word_at(store, 5'd6);
      res_in.pm25           = view.is_new ? word_at(store, 5'd9)  : word_at(store, 5'd8);
      res_in.pm10           = view.is_new ? word_at(store, 5'd11) : word_at(store, 5'd10);
      res_in.temperature_tenths = temp;
      res_in.humidity_tenths    = h_raw;

      implausible = (res_in.pm25 > cfg.pm_limit) || (res_in.pm10 > cfg.pm_limit) ||
                    (temp < cfg.temp_min) || (temp > cfg.temp_max) ||
                    (h_raw > cfg.hum_max);

      if (!view.is_new && (store[1] != LEGACY_SECOND)) begin
         res_in.status = STATUS_HEADER;
      end else if (!view.is_new && (view.sum[6:0] != view.last_byte[6:0])) begin
         res_in.status = STATUS_CHECKSUM;
      end else if (implausible) begin
         res_in.status = STATUS_IMPLAUS;
      end else begin
         res_in.status = STATUS_OK;
      end
   end

   assign busy     = valid_ff && !rsp.ready;
   assign valid_in = view.done || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (view.done) begin
         res_ff <= res_in;
      end
   end

   assign rsp.valid              = valid_ff;
   assign rsp.frame_kind         = res_ff.frame_kind;
   assign rsp.status             = res_ff.status;
   assign rsp.device_address     = res_ff.device_address;
   assign rsp.function_code      = res_ff.function_code;
   assign rsp.co2_ppm            = res_ff.co2_ppm;
   assign rsp.formaldehyde       = res_ff.formaldehyde;
   assign rsp.tvoc               = res_ff.tvoc;
   assign rsp.pm25               = res_ff.pm25;
   assign rsp.pm10               = res_ff.pm10;
   assign rsp.temperature_tenths = res_ff.temperature_tenths;
   assign rsp.humidity_tenths    = res_ff.humidity_tenths;

   a_legacy_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !res_ff.frame_kind) |->
         (res_ff.device_address == 8'd0) && (res_ff.function_code == 16'd0))
      else $error("legacy result carries address or function");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      view.done |-> !(valid_ff && !rsp.ready))
      else $error("frame closed while a result was stalled");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp.ready) |=> valid_ff && $stable(res_ff))
      else $error("stalled result changed or vanished");

endmodule

>>> rtl/core/air_quality_frame_parser.sv
// Channel   Direction  Transaction                       Handshake
// req_chan  in         one received sensor byte          valid/ready
// rsp_chan  out        one decoded frame with a status   valid/ready
// csr       in         APB-style register write/read     psel/penable, pready tied high
//
// One byte per cycle sustained; a frame's result appears in the output
// register the cycle after its closing byte is taken (17 or 19 bytes/frame).
// Synchronous active-high reset: hunting, no result pending, limits at defaults.
// A stalled result blocks only the closing byte of the next frame; every other
// byte keeps flowing into the framer.
module air_quality_frame_parser (
   input  logic                            clock,
   input  logic                            reset,
   aqfp_req_if.sink                        req_chan,
   aqfp_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [aqfp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [aqfp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [aqfp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import aqfp_pkg::*;

   cfg_type         cfg;
   frame_view_type  view;
   frame_store_type store;
   logic            busy;
   logic            accept;

   // limits for the plausibility check
   aqfp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // only the closing byte needs room in the output register
   assign req_chan.ready = !view.at_last || !busy;
   assign accept         = req_chan.valid && req_chan.ready;

   // preamble hunt, byte collection, running sum
   aqfp_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_chan.rx_byte),
      .view    (view),
      .store   (store)
   );

   // field decode, status, result register
   aqfp_decode u_decode (
      .clock (clock),
      .reset (reset),
      .view  (view),
      .store (store),
      .cfg   (cfg),
      .busy  (busy),
      .rsp   (rsp_chan)
   );

   a_ready_mid_frame: assert property (@(posedge clock) disable iff (reset)
      !view.at_last |-> req_chan.ready)
      else $error("input stalled on a byte that cannot produce a result");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      view.done |=> rsp_chan.valid)
      else $error("closed frame gave no result");

   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      view.done |=> (rsp_chan.frame_kind == $past(view.is_new)))
      else $error("result kind differs from the closed frame");

endmodule

>>> tb/aqfp_frame_checker.sv
module aqfp_frame_checker (
   input  logic                            clock,
   input  logic                            reset,
   aqfp_req_if                             req,
   aqfp_rsp_if                             rsp,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [aqfp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [aqfp_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                            pready,
   output int unsigned                     fail_count,
   output int unsigned                     frames_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import aqfp_pkg::*;

   localparam logic        [15:0] PM_LIMIT_RST = 16'd1000;
   localparam logic signed [11:0] TEMP_MIN_RST = -12'sd400;
   localparam logic signed [11:0] TEMP_MAX_RST = 12'sd800;
   localparam logic        [11:0] HUM_MAX_RST  = 12'd1000;
   localparam int                 PRINT_CAP    = 100;

   typedef struct packed {
      logic               frame_kind;
      status_type         status;
      logic        [7:0]  device_address;
      logic        [15:0] function_code;
      logic        [15:0] co2_ppm;
      logic        [15:0] formaldehyde;
      logic        [15:0] tvoc;
      logic        [15:0] pm25;
      logic        [15:0] pm10;
      logic signed [11:0] temperature_tenths;
      logic        [11:0] humidity_tenths;
   } frame_report_type;

   // framer shadow
   logic             in_frame;
   logic             is_new;
   logic [IDX_W-1:0] slot;
   logic [7:0]       run_sum;
   logic [7:0]       frame_buf [FRAME_MAX];
   cfg_type          limits;

   frame_report_type pending_frames [$];
   int unsigned      mismatches   = 0;
   int unsigned      results_seen = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < PRINT_CAP)
         $display("%0t ns frame %0d: %s got 0x%0h want 0x%0h", $time, results_seen, what,
                  got, want);
      mismatches++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   function automatic logic [15:0] word_at(input int i);
      return {frame_buf[i], frame_buf[i+1]};
   endfunction

   // decode of a completed frame, using the limits in force at its closing byte
   function automatic frame_report_type decode_frame();
      frame_report_type r;
      int               off;
      int               t;
      int               h;
      off = is_new ? 3 : 2;
      t = int'(frame_buf[off+10]) * 10 + int'(frame_buf[off+11]);
      h = int'(frame_buf[off+12]) * 10 + int'(frame_buf[off+13]);
      // sign-magnitude temperature: values past the offset count downward from zero
      if (t > int'(TEMP_OFFSET))
         t = int'(TEMP_OFFSET) - t;

      r.frame_kind         = is_new;
      r.device_address     = is_new ? frame_buf[0] : 8'h00;
      r.function_code      = is_new ? word_at(1) : 16'h0000;
      r.co2_ppm            = word_at(off);
      r.formaldehyde       = word_at(off + 2);
      r.tvoc               = word_at(off + 4);
      r.pm25               = word_at(off + 6);
      r.pm10               = word_at(off + 8);
      r.temperature_tenths = t[11:0];
      r.humidity_tenths    = h[11:0];

      if (!is_new && frame_buf[1] != LEGACY_SECOND)
         r.status = STATUS_HEADER;
      else if (!is_new && run_sum[6:0] != frame_buf[LAST_IDX_LEGACY][6:0])
         r.status = STATUS_CHECKSUM;
      else if (r.pm25 > limits.pm_limit || r.pm10 > limits.pm_limit ||
               t < int'(limits.temp_min) || t > int'(limits.temp_max) ||
               h > int'(limits.hum_max))
         r.status = STATUS_IMPLAUS;
      else
         r.status = STATUS_OK;
      return r;
   endfunction

   task automatic absorb_byte(input logic [7:0] b);
      logic [IDX_W-1:0] last;
      if (!in_frame) begin
         if (b == PRE_LEGACY || b == PRE_NEW) begin
            in_frame     = 1'b1;
            is_new       = (b == PRE_NEW);
            frame_buf[0] = b;
            slot         = FIRST_DATA_IDX;
            run_sum      = b;
         end
      end else begin
         last = is_new ? LAST_IDX_NEW : LAST_IDX_LEGACY;
         frame_buf[slot] = b;
         if (slot == last) begin
            pending_frames.insert(pending_frames.size(), decode_frame());
            in_frame = 1'b0;
            slot     = '0;
            run_sum  = '0;
         end else begin
            run_sum = run_sum + b;
            slot    = slot + 1'b1;
         end
      end
   endtask

   task automatic apply_write(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_PM_LIMIT: limits.pm_limit = value[15:0];
         REG_TEMP_MIN: limits.temp_min = value[11:0];
         REG_TEMP_MAX: limits.temp_max = value[11:0];
         REG_HUM_MAX:  limits.hum_max  = value[11:0];
         default: ;
      endcase
   endtask

   task automatic compare_result();
      frame_report_type want;
      if (pending_frames.size() == 0) begin
         report_mismatch("result with no frame outstanding", rsp.status, 0);
      end else begin
         want = pending_frames.pop_front();
         check_field("frame_kind", rsp.frame_kind, want.frame_kind);
         check_field("status", rsp.status, want.status);
         check_field("device_address", rsp.device_address, want.device_address);
         check_field("function_code", rsp.function_code, want.function_code);
         check_field("co2_ppm", rsp.co2_ppm, want.co2_ppm);
         check_field("formaldehyde", rsp.formaldehyde, want.formaldehyde);
         check_field("tvoc", rsp.tvoc, want.tvoc);
         check_field("pm25", rsp.pm25, want.pm25);
         check_field("pm10", rsp.pm10, want.pm10);
         check_field("temperature_tenths", rsp.temperature_tenths,
                     want.temperature_tenths);
         check_field("humidity_tenths", rsp.humidity_tenths, want.humidity_tenths);
      end
      results_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         in_frame        = 1'b0;
         is_new          = 1'b0;
         slot            = '0;
         run_sum         = '0;
         limits.pm_limit = PM_LIMIT_RST;
         limits.temp_min = TEMP_MIN_RST;
         limits.temp_max = TEMP_MAX_RST;
         limits.hum_max  = HUM_MAX_RST;
         pending_frames.delete();
      end else begin
         // result first: it belongs to an earlier frame than any byte taken now
         if (rsp.valid && rsp.ready)
            compare_result();
         if (psel && penable && pwrite && pready)
            apply_write(paddr[CSR_ADDR_W-1 -: 2], pwdata);
         if (req.valid && req.ready)
            absorb_byte(req.rx_byte);
      end
      fail_count     <= mismatches;
      frames_pending <= pending_frames.size();
   end

endmodule

>>> tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import aqfp_pkg::*;

   // Generous: ~1.4k bytes at worst-case gaps plus a long result stall on every
   // frame stays well within this limit.
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int PHASE_BYTES  = 175;
   localparam int DRAIN_CYCLES = 4;

   typedef logic [7:0] frame_type [FRAME_MAX];

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int unsigned fail_count;
   int unsigned frames_pending;
   int unsigned cycle_count = 0;
   int unsigned bytes_sent  = 0;

   // calm stretches: no gaps on the byte side / no stalls on the result side
   bit calm_req  = 1'b0;
   bit calm_rsp  = 1'b0;
   int stall_left = 0;

   aqfp_req_if req_if ();
   aqfp_rsp_if rsp_if ();

   air_quality_frame_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   aqfp_frame_checker frame_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_if),
      .rsp            (rsp_if),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .fail_count     (fail_count),
      .frames_pending (frames_pending)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result-side backpressure: mostly short stalls, now and then a long one,
   // and calm stretches where ready stays high.
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0)
         calm_rsp <= !calm_rsp;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (!calm_rsp && $urandom_range(0, 99) < 15) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Gap before a byte: none in calm stretches, otherwise mostly short.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm_req || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // One byte transaction. valid stays high afterwards so back-to-back bytes
   // need no extra assignment; a gap drops it first.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Send the first cut bytes of a frame (whole frame when cut is 0 or too big).
   // seal fixes the low 7 bits of a legacy checksum and keeps bit 7 as given.
   task automatic send_frame(input frame_type f, input bit is_new, input bit seal,
                             input int cut);
      logic [7:0] s;
      int         flen;
      int         n;
      flen = is_new ? int'(LAST_IDX_NEW) + 1 : int'(LAST_IDX_LEGACY) + 1;
      n    = (cut > 0 && cut < flen) ? cut : flen;
      if (!is_new && seal) begin
         s = 8'h00;
         for (int i = 0; i < int'(LAST_IDX_LEGACY); i++)
            s = s + f[i];
         f[LAST_IDX_LEGACY][6:0] = s[6:0];
      end
      for (int i = 0; i < n; i++)
         send_byte(f[i]);
   endtask

   function automatic frame_type blank_frame(input bit is_new, input logic [7:0] fill);
      frame_type f;
      foreach (f[i]) f[i] = fill;
      f[0] = is_new ? PRE_NEW : PRE_LEGACY;
      if (!is_new)
         f[1] = LEGACY_SECOND;
      return f;
   endfunction

   // Random frame; readings are usually kept near the plausibility limits so
   // every status shows up, the rest fully random.
   task automatic send_random_frame(input bit truncate);
      frame_type   f;
      bit          is_new;
      int          off;
      int          flen;
      logic [15:0] w;
      is_new = $urandom_range(0, 1);
      off    = is_new ? 3 : 2;
      flen   = is_new ? int'(LAST_IDX_NEW) + 1 : int'(LAST_IDX_LEGACY) + 1;
      foreach (f[i]) f[i] = 8'($urandom);
      f[0] = is_new ? PRE_NEW : PRE_LEGACY;
      if ($urandom_range(0, 3) != 0) begin
         w = 16'($urandom_range(0, 1100));
         f[off+6] = w[15:8];
         f[off+7] = w[7:0];
         w = 16'($urandom_range(0, 1100));
         f[off+8]  = w[15:8];
         f[off+9]  = w[7:0];
         f[off+10] = 8'($urandom_range(0, 170));
         f[off+11] = 8'($urandom_range(0, 9));
         f[off+12] = 8'($urandom_range(0, 110));
         f[off+13] = 8'($urandom_range(0, 9));
      end
      if (!is_new && $urandom_range(0, 9) != 0)
         f[1] = LEGACY_SECOND;
      send_frame(f, is_new, $urandom_range(0, 6) != 0,
                 truncate ? $urandom_range(1, flen - 1) : 0);
   endtask

   task automatic run_directed();
      frame_type f;
      // line noise while hunting, no preamble among it
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(LEGACY_SECOND);
      send_byte(8'h80);
      // all-zero and all-ones content, both frame kinds
      send_frame(blank_frame(1'b0, 8'h00), 1'b0, 1'b1, 0);
      send_frame(blank_frame(1'b0, 8'hFF), 1'b0, 1'b1, 0);
      send_frame(blank_frame(1'b1, 8'hFF), 1'b1, 1'b1, 0);
      send_frame(blank_frame(1'b1, 8'h00), 1'b1, 1'b1, 0);
      // preamble values inside a frame are plain data
      f = blank_frame(1'b1, PRE_NEW);
      f[1] = PRE_LEGACY;
      send_frame(f, 1'b1, 1'b1, 0);
      // temperature past the offset reads negative; exactly the offset does not
      f = blank_frame(1'b0, 8'h00);
      f[12] = 8'd140;
      f[13] = 8'd5;
      send_frame(f, 1'b0, 1'b1, 0);
      f[12] = 8'd128;
      f[13] = 8'd0;
      send_frame(f, 1'b0, 1'b1, 0);
      f[13] = 8'd1;
      send_frame(f, 1'b0, 1'b1, 0);
      // everything right at the default limits, then one tenth past
      f = blank_frame(1'b0, 8'h00);
      f[8]  = 8'h03;
      f[9]  = 8'hE8;
      f[10] = 8'h03;
      f[11] = 8'hE8;
      f[12] = 8'd80;
      f[14] = 8'd100;
      send_frame(f, 1'b0, 1'b1, 0);
      f[13] = 8'd1;
      send_frame(f, 1'b0, 1'b1, 0);
      f[12] = 8'd168;
      f[13] = 8'd0;
      send_frame(f, 1'b0, 1'b1, 0);
      f[13] = 8'd1;
      send_frame(f, 1'b0, 1'b1, 0);
      // checksum: wrong low bits, then differing only in the ignored bit 7
      f = blank_frame(1'b0, 8'h00);
      f[16] = 8'h05;
      send_frame(f, 1'b0, 1'b0, 0);
      f[16] = 8'h80;
      send_frame(f, 1'b0, 1'b1, 0);
      // bad header wins over bad checksum; bad header with a good checksum
      f = blank_frame(1'b0, 8'h00);
      f[1] = 8'h03;
      send_frame(f, 1'b0, 1'b0, 0);
      f[1] = 8'hFF;
      send_frame(f, 1'b0, 1'b1, 0);
   endtask

   // Mostly well-formed frames, some noise and some frames cut short (the
   // next preamble then lands inside the cut frame as data).
   task automatic run_random(input int n_bytes);
      int unsigned start;
      int          r;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         if ($urandom_range(0, 29) == 0)
            calm_req = !calm_req;
         r = $urandom_range(0, 99);
         if (r < 80) begin
            send_random_frame(1'b0);
         end else if (r < 92) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end else begin
            send_random_frame(1'b1);
         end
      end
   endtask

   // Block idle: no byte offered, every decoded frame handed over, then a
   // drain wait for the output register to empty.
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (frames_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write: setup cycle then access cycle. psel/penable stay up so
   // back-to-back writes never assign a signal twice in one step.
   task automatic write_reg(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
   endtask

   task automatic set_limits(input int pm, input int tmin, input int tmax, input int hum);
      write_reg(REG_PM_LIMIT, pm);
      write_reg(REG_TEMP_MIN, tmin);
      write_reg(REG_TEMP_MAX, tmax);
      write_reg(REG_HUM_MAX, hum);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= 8'h00;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset limits first
      run_directed();
      settle();

      // narrowest limits: every well-formed frame is implausible
      set_limits(0, 1280, -1525, 0);
      run_random(PHASE_BYTES);
      settle();

      // widest limits: only header and checksum can fail
      set_limits(65535, -1525, 1280, 2805);
      run_random(PHASE_BYTES);
      settle();

      set_limits(500, -100, 300, 600);
      run_random(PHASE_BYTES);
      settle();

      repeat (2) begin
         set_limits($urandom_range(200, 1200), -int'($urandom_range(0, 500)),
                    $urandom_range(200, 1280), $urandom_range(300, 1100));
         run_random(PHASE_BYTES);
         settle();
      end

      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
